// ===== rtl/pfsa_pkg.sv =====
// Shared types, codes and sizing constants for the page-frame stack allocator.
package pfsa_pkg;

    localparam int FRAME_BITS            = 20;
    localparam int COUNT_BITS            = 15;
    localparam int DEF_ENTRIES_PER_PAGE  = 1024;
    localparam int DEF_MAX_BACKING_PAGES = 16;

    typedef enum logic
    {
        CMD_FREE  = 1'b0,
        CMD_ALLOC = 1'b1
    } cmd_t;

    typedef enum logic [1:0]
    {
        ST_OK      = 2'd0,
        ST_OOM     = 2'd1,
        ST_BACKING = 2'd2,
        ST_FULL    = 2'd3
    } status_t;

    typedef struct packed
    {
        cmd_t                  command;
        logic [FRAME_BITS-1:0] frame_number;
    } alloc_in_t;

    typedef struct packed
    {
        logic [FRAME_BITS-1:0] granted_frame;
        status_t               status;
        logic [COUNT_BITS-1:0] free_count;
    } alloc_out_t;

    // Commands from the controller to the datapath.
    typedef struct packed
    {
        logic load;
        logic exec;
    } pfsa_ctl_t;

endpackage

// ===== rtl/pfsa_ctrl.sv =====
// Controller state machine that sequences the fetch and execute cycles of each transaction.
module pfsa_ctrl
    import pfsa_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    output pfsa_ctl_t ctl
);

    typedef enum logic [1:0]
    {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    ctl.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                ctl.exec   = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

endmodule

// ===== rtl/pfsa_datapath.sv =====
// Datapath holding the frame stack, the backing-page record, the counters and the result register.
module pfsa_datapath
    import pfsa_pkg::*;
#(
    parameter int ENTRIES_PER_PAGE  = DEF_ENTRIES_PER_PAGE,
    parameter int MAX_BACKING_PAGES = DEF_MAX_BACKING_PAGES
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  pfsa_ctl_t  ctl,
    input  alloc_in_t  request,
    output alloc_out_t result,
    output logic       done
);

    localparam int DEPTH = ENTRIES_PER_PAGE * MAX_BACKING_PAGES;
    localparam int UW    = $clog2(DEPTH + 1);
    localparam int SAW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int BW    = $clog2(MAX_BACKING_PAGES + 1);
    localparam int BAW   = (MAX_BACKING_PAGES > 1) ? $clog2(MAX_BACKING_PAGES) : 1;

    logic [FRAME_BITS-1:0] frame_store    [DEPTH];
    logic [FRAME_BITS-1:0] backing_frames [MAX_BACKING_PAGES];

    cmd_t                  cmd_reg;
    logic [FRAME_BITS-1:0] frame_reg;
    logic [FRAME_BITS-1:0] store_rd_reg;
    logic [FRAME_BITS-1:0] back_rd_reg;

    logic [UW-1:0]         used_reg;
    logic [UW-1:0]         used_next;
    logic [UW-1:0]         cap_reg;
    logic [UW-1:0]         cap_next;
    logic [BW-1:0]         back_reg;
    logic [BW-1:0]         back_next;

    alloc_out_t            result_reg;
    alloc_out_t            result_next;
    logic                  done_reg;

    logic                  store_we;
    logic                  back_we;
    logic [UW-1:0]         used_dec;
    logic [BW-1:0]         back_dec;

    assign used_dec = used_reg - UW'(1);
    assign back_dec = back_reg - BW'(1);

    // Both tops are fetched when the transaction is taken, so a pop has its data in the following cycle.
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            cmd_reg      <= request.command;
            frame_reg    <= request.frame_number;
            store_rd_reg <= frame_store[used_dec[SAW-1:0]];
            back_rd_reg  <= backing_frames[back_dec[BAW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (store_we)
        begin
            frame_store[used_reg[SAW-1:0]] <= frame_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (back_we)
        begin
            backing_frames[back_reg[BAW-1:0]] <= frame_reg;
        end
    end

    always_comb
    begin
        used_next   = used_reg;
        cap_next    = cap_reg;
        back_next   = back_reg;
        store_we    = 1'b0;
        back_we     = 1'b0;
        result_next = result_reg;
        if (ctl.exec)
        begin
            result_next.granted_frame = '0;
            result_next.status        = ST_OK;
            unique case (cmd_reg)
                CMD_FREE:
                begin
                    // Capacity never exceeds the store depth, so this also bounds the store.
                    if (used_reg < cap_reg)
                    begin
                        store_we  = 1'b1;
                        used_next = used_reg + UW'(1);
                    end
                    else if (back_reg < BW'(MAX_BACKING_PAGES))
                    begin
                        back_we            = 1'b1;
                        back_next          = back_reg + BW'(1);
                        cap_next           = cap_reg + UW'(ENTRIES_PER_PAGE);
                        result_next.status = ST_BACKING;
                    end
                    else
                    begin
                        result_next.status = ST_FULL;
                    end
                end
                CMD_ALLOC:
                begin
                    if (used_reg != '0)
                    begin
                        used_next                 = used_dec;
                        result_next.granted_frame = store_rd_reg;
                    end
                    else if (back_reg != '0)
                    begin
                        back_next                 = back_dec;
                        cap_next                  = cap_reg - UW'(ENTRIES_PER_PAGE);
                        result_next.granted_frame = back_rd_reg;
                    end
                    else
                    begin
                        result_next.status = ST_OOM;
                    end
                end
                default:
                begin
                    result_next.status = ST_OK;
                end
            endcase
            result_next.free_count = COUNT_BITS'(used_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= '0;
            cap_reg  <= '0;
            back_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            used_reg <= used_next;
            cap_reg  <= cap_next;
            back_reg <= back_next;
            done_reg <= ctl.exec;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign result = result_reg;
    assign done   = done_reg;

endmodule

// ===== rtl/page_frame_stack_allocator.sv =====
// Timing: a taken transaction loads the request and both stack tops, then runs in the execute
// state; its result is registered, with done high for one cycle, and the receiver cannot hold it off.
// Transactions: the registered read of the stack top precedes the execute state, and busy is high
// during that execute state, when start is ignored, so a new transaction waits for the last one.
// Reset: stack, capacity and backing counts clear at once; no clearing pass is needed.
module page_frame_stack_allocator
    import pfsa_pkg::*;
#(
    parameter int ENTRIES_PER_PAGE  = DEF_ENTRIES_PER_PAGE,
    parameter int MAX_BACKING_PAGES = DEF_MAX_BACKING_PAGES
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  alloc_in_t  request,
    output alloc_out_t result,
    output logic       done
);

    pfsa_ctl_t ctl;

    pfsa_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .ctl   (ctl)
    );

    pfsa_datapath
    #(
        .ENTRIES_PER_PAGE  (ENTRIES_PER_PAGE),
        .MAX_BACKING_PAGES (MAX_BACKING_PAGES)
    )
    u_datapath
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (ctl),
        .request (request),
        .result  (result),
        .done    (done)
    );

endmodule
